// ----- src/kda_pkg.sv -----
// Shared types and constants for the key debounce / auto-repeat block.
// No dependencies; used by every module under src.
package kda_pkg;

    localparam int HISTORY_BITS_DEF = 8;
    localparam int CFG_INDEX_W      = 4;
    localparam int CFG_DATA_W       = 8;

    localparam logic [7:0] CNT_MAX = 8'hff;
    localparam logic [7:0] ONE     = 8'h01;

    typedef enum logic [1:0] {
        CLS_RELEASED  = 2'd0,
        CLS_PRESSED   = 2'd1,
        CLS_UNDECIDED = 2'd2
    } cls_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KEY_PRESENT    = 4'd0,
        REG_ENABLE_FLAGS   = 4'd1,
        REG_FILTER_MASK    = 4'd2,
        REG_INVERT_LOGIC   = 4'd3,
        REG_LONG_RELOAD    = 4'd4,
        REG_SHORT_RELOAD   = 4'd5,
        REG_FAST_AFTER     = 4'd6,
        REG_MULTIPLY_AFTER = 4'd7
    } reg_idx_t;

    // enable_flags bit positions
    localparam int EN_KEY      = 0;
    localparam int EN_REPEAT   = 1;
    localparam int EN_FAST     = 2;
    localparam int EN_MULTIPLY = 3;

    localparam logic [0:0] OP_TICK = 1'b0;
    localparam logic [0:0] OP_ACK  = 1'b1;

    typedef struct packed {
        logic       key_present;
        logic [3:0] enable_flags;
        logic [7:0] filter_mask;
        logic       invert_logic;
        logic [7:0] long_reload;
        logic [7:0] short_reload;
        logic [7:0] fast_after;
        logic [7:0] multiply_after;
    } cfg_t;

    typedef struct packed {
        logic       pressed_flag;
        logic       multiply_flag;
        logic [1:0] filtered_state;
        logic [7:0] press_count;
    } result_t;

endpackage

// ----- src/kda_cfg_regs.sv -----
// Configuration register file for the key debounce block.
// Depends on kda_pkg for the register index codes and cfg_t.
module kda_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [kda_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [kda_pkg::CFG_DATA_W-1:0]      cfg_data,
    output kda_pkg::cfg_t                       cfg
);

    kda_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_present    <= 1'b0;
            cfg_reg.enable_flags   <= 4'd0;
            cfg_reg.filter_mask    <= 8'd15;
            cfg_reg.invert_logic   <= 1'b0;
            cfg_reg.long_reload    <= 8'd50;
            cfg_reg.short_reload   <= 8'd10;
            cfg_reg.fast_after     <= 8'd5;
            cfg_reg.multiply_after <= 8'd10;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                kda_pkg::REG_KEY_PRESENT:    cfg_reg.key_present    <= cfg_data[0];
                kda_pkg::REG_ENABLE_FLAGS:   cfg_reg.enable_flags   <= cfg_data[3:0];
                kda_pkg::REG_FILTER_MASK:    cfg_reg.filter_mask    <= cfg_data;
                kda_pkg::REG_INVERT_LOGIC:   cfg_reg.invert_logic   <= cfg_data[0];
                kda_pkg::REG_LONG_RELOAD:    cfg_reg.long_reload    <= cfg_data;
                kda_pkg::REG_SHORT_RELOAD:   cfg_reg.short_reload   <= cfg_data;
                kda_pkg::REG_FAST_AFTER:     cfg_reg.fast_after     <= cfg_data;
                kda_pkg::REG_MULTIPLY_AFTER: cfg_reg.multiply_after <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/kda_core.sv -----
// Debounce state and single-pass update logic: history, classifier, timer, counter.
// Depends on kda_pkg for cfg_t, result_t and the class codes.
module kda_core
#(
    parameter int HISTORY_BITS = kda_pkg::HISTORY_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             op,
    input  logic             raw,
    input  kda_pkg::cfg_t    cfg,
    output kda_pkg::result_t result
);

    localparam int MW = (HISTORY_BITS > 8) ? HISTORY_BITS : 8;

    logic [HISTORY_BITS-1:0] history_reg, history_next;
    logic [7:0]              timer_reg, timer_next;
    logic [7:0]              count_reg, count_next;
    logic                    held_reg, held_next;
    logic                    multi_reg, multi_next;
    kda_pkg::cls_t           class_reg, class_next;

    logic [MW-1:0]           mask_ext;
    logic [HISTORY_BITS-1:0] mask;
    logic [HISTORY_BITS-1:0] shifted;
    logic [HISTORY_BITS-1:0] masked;
    kda_pkg::cls_t           cls;
    logic [7:0]              count_inc;
    logic [7:0]              timer_load;

    assign mask_ext = MW'(cfg.filter_mask);
    assign mask     = mask_ext[HISTORY_BITS-1:0];
    assign shifted  = {history_reg[HISTORY_BITS-2:0], raw};
    assign masked   = shifted & mask;

    always_comb
    begin
        if (!cfg.enable_flags[kda_pkg::EN_KEY])
            cls = kda_pkg::CLS_RELEASED;
        else if (masked == mask)
            cls = cfg.invert_logic ? kda_pkg::CLS_RELEASED : kda_pkg::CLS_PRESSED;
        else if (masked == '0)
            cls = cfg.invert_logic ? kda_pkg::CLS_PRESSED : kda_pkg::CLS_RELEASED;
        else
            cls = kda_pkg::CLS_UNDECIDED;
    end

    assign count_inc = (count_reg == kda_pkg::CNT_MAX) ? count_reg : count_reg + kda_pkg::ONE;

    always_comb
    begin
        history_next = history_reg;
        timer_next   = timer_reg;
        count_next   = count_reg;
        held_next    = held_reg;
        multi_next   = multi_reg;
        class_next   = class_reg;
        timer_load   = timer_reg;
        if (op == kda_pkg::OP_ACK)
        begin
            held_next  = 1'b0;
            multi_next = 1'b0;
        end
        else
        begin
            history_next = shifted;
            class_next   = cls;
            if (cfg.key_present)
            begin
                case (cls)
                    kda_pkg::CLS_RELEASED:
                    begin
                        held_next  = 1'b0;
                        multi_next = 1'b0;
                        timer_next = '0;
                        count_next = '0;
                    end
                    kda_pkg::CLS_PRESSED:
                    begin
                        if (timer_reg == '0)
                        begin
                            held_next  = 1'b1;
                            count_next = count_inc;
                            if (count_inc > cfg.fast_after && cfg.enable_flags[kda_pkg::EN_FAST])
                                timer_load = cfg.short_reload;
                            else
                                timer_load = cfg.long_reload;
                            if (count_inc > cfg.multiply_after
                                && cfg.enable_flags[kda_pkg::EN_MULTIPLY])
                                multi_next = 1'b1;
                        end
                        // count down after any reload while repeat is enabled
                        if (timer_load != '0 && cfg.enable_flags[kda_pkg::EN_REPEAT])
                            timer_next = timer_load - kda_pkg::ONE;
                        else
                            timer_next = timer_load;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg <= '0;
            timer_reg   <= '0;
            count_reg   <= '0;
            held_reg    <= 1'b0;
            multi_reg   <= 1'b0;
            class_reg   <= kda_pkg::CLS_RELEASED;
        end
        else if (step)
        begin
            history_reg <= history_next;
            timer_reg   <= timer_next;
            count_reg   <= count_next;
            held_reg    <= held_next;
            multi_reg   <= multi_next;
            class_reg   <= class_next;
        end
    end

    assign result.pressed_flag   = held_next;
    assign result.multiply_flag  = multi_next;
    assign result.filtered_state = class_next;
    assign result.press_count    = count_next;

endmodule

// ----- src/kda_out_buf.sv -----
// Two-entry result buffer that decouples the update stage from the output channel.
// Depends on kda_pkg for result_t.
module kda_out_buf
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  kda_pkg::result_t push_data,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output kda_pkg::result_t head
);

    logic [1:0]       count_reg, count_next;
    kda_pkg::result_t slot0_reg, slot0_next;
    kda_pkg::result_t slot1_reg, slot1_next;

    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (push && pop)
        begin
            if (count_reg == 2'd1)
                slot0_next = push_data;
            else
            begin
                slot0_next = slot1_reg;
                slot1_next = push_data;
            end
        end
        else if (push)
        begin
            count_next = count_reg + 2'd1;
            if (count_reg == 2'd0)
                slot0_next = push_data;
            else
                slot1_next = push_data;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot0_reg;

endmodule

// ----- src/key_debounce_autorepeat_core.sv -----
// Top level of the key debounce / auto-repeat block.
// Depends on kda_pkg, kda_cfg_regs, kda_core and kda_out_buf.
//
// Usage:
//   Input channel (in_valid / in_stall) carries op and raw_pressed: op 0 is a
//   sample tick, op 1 an acknowledge that clears the pressed and multiply flags.
//   Output channel (out_valid / out_stall) returns one result item per input
//   item: pressed_flag, multiply_flag, filtered_state and press_count.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
//   one register per handshake; cfg_ready is always high. Write only while idle.
// Timing:
//   An item is taken into an input register, updated in one pass through the
//   classifier, timer and counter logic, and lands in a two-entry result
//   buffer: throughput one item per cycle while out_stall stays low.
//   While the receiver stalls the buffer absorbs up to two results plus one in
//   the input register; then in_stall rises until out_stall drops.
// Reset:
//   rst_n clears all debounce state, empties the buffer and loads the
//   configuration defaults. No clearing pass; items are taken right after reset.
module key_debounce_autorepeat_core
#(
    parameter int HISTORY_BITS = kda_pkg::HISTORY_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            op,
    input  logic                            raw_pressed,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            pressed_flag,
    output logic                            multiply_flag,
    output logic [1:0]                      filtered_state,
    output logic [7:0]                      press_count,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kda_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [kda_pkg::CFG_DATA_W-1:0]  cfg_data
);

    kda_pkg::cfg_t    cfg;
    kda_pkg::result_t result;
    kda_pkg::result_t head;

    logic stage_valid_reg;
    logic stage_op_reg;
    logic stage_raw_reg;
    logic buf_full;
    logic buf_not_empty;
    logic accept;
    logic advance;
    logic pop;

    assign cfg_ready = 1'b1;

    kda_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance  = stage_valid_reg && !buf_full;
    assign in_stall = stage_valid_reg && buf_full;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (accept)
            stage_valid_reg <= 1'b1;
        else if (advance)
            stage_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_op_reg  <= op;
            stage_raw_reg <= raw_pressed;
        end
    end

    kda_core #(.HISTORY_BITS(HISTORY_BITS)) u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .op     (stage_op_reg),
        .raw    (stage_raw_reg),
        .cfg    (cfg),
        .result (result)
    );

    assign pop = buf_not_empty && !out_stall;

    kda_out_buf u_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (advance),
        .push_data (result),
        .pop       (pop),
        .full      (buf_full),
        .not_empty (buf_not_empty),
        .head      (head)
    );

    assign out_valid      = buf_not_empty;
    assign pressed_flag   = head.pressed_flag;
    assign multiply_flag  = head.multiply_flag;
    assign filtered_state = head.filtered_state;
    assign press_count    = head.press_count;

endmodule

// ----- dv/tb_key_debounce_autorepeat_core.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for key_debounce_autorepeat_core: directed presses, repeats and
// corner settings, then random keystrokes under random idling. Needs kda_pkg and the DUT.
module tb_key_debounce_autorepeat_core;

    localparam int          HB          = kda_pkg::HISTORY_BITS_DEF;
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic                            clk         = 1'b0;
    logic                            rst_n       = 1'b0;
    logic                            in_valid    = 1'b0;
    logic                            in_stall;
    logic                            op          = kda_pkg::OP_TICK;
    logic                            raw_pressed = 1'b0;
    logic                            out_valid;
    logic                            out_stall   = 1'b0;
    logic                            pressed_flag;
    logic                            multiply_flag;
    logic [1:0]                      filtered_state;
    logic [7:0]                      press_count;
    logic                            cfg_valid   = 1'b0;
    logic                            cfg_ready;
    logic [kda_pkg::CFG_INDEX_W-1:0] cfg_index   = kda_pkg::REG_KEY_PRESENT;
    logic [kda_pkg::CFG_DATA_W-1:0]  cfg_data    = '0;

    // mirror of the register file and of the debounce state
    kda_pkg::cfg_t kcfg = '{key_present: 1'b0, enable_flags: 4'h0, filter_mask: 8'd15,
                            invert_logic: 1'b0, long_reload: 8'd50, short_reload: 8'd10,
                            fast_after: 8'd5, multiply_after: 8'd10};
    logic [HB-1:0] hist_q  = '0;
    logic [7:0]    timer_q = '0;
    logic [7:0]    count_q = '0;
    logic          held_q  = 1'b0;
    logic          multi_q = 1'b0;
    kda_pkg::cls_t class_q = kda_pkg::CLS_RELEASED;

    kda_pkg::result_t expected_reports[$];
    int unsigned      items_sent    = 0;
    int unsigned      errors        = 0;
    int unsigned      cycles        = 0;
    int unsigned      send_idle_pct = 0;
    int unsigned      recv_idle_pct = 0;

    key_debounce_autorepeat_core i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .raw_pressed    (raw_pressed),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .pressed_flag   (pressed_flag),
        .multiply_flag  (multiply_flag),
        .filtered_state (filtered_state),
        .press_count    (press_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Advance the debounce state by one item and return the report it produces.
    function automatic kda_pkg::result_t debounce_step(input logic op_bit,
                                                       input logic raw_bit);
        kda_pkg::result_t rep;
        kda_pkg::cls_t    cls;
        logic [HB-1:0]    sel;
        if (op_bit == kda_pkg::OP_ACK)
        begin
            held_q  = 1'b0;
            multi_q = 1'b0;
        end
        else
        begin
            hist_q = {hist_q[HB-2:0], raw_bit};
            sel    = hist_q & kcfg.filter_mask[HB-1:0];
            // an empty mask matches all-ones first, so it reads as pressed
            if (!kcfg.enable_flags[kda_pkg::EN_KEY])
                cls = kda_pkg::CLS_RELEASED;
            else if (sel == kcfg.filter_mask[HB-1:0])
                cls = kcfg.invert_logic ? kda_pkg::CLS_RELEASED : kda_pkg::CLS_PRESSED;
            else if (sel == '0)
                cls = kcfg.invert_logic ? kda_pkg::CLS_PRESSED : kda_pkg::CLS_RELEASED;
            else
                cls = kda_pkg::CLS_UNDECIDED;
            class_q = cls;
            if (kcfg.key_present)
            begin
                if (cls == kda_pkg::CLS_RELEASED)
                begin
                    held_q  = 1'b0;
                    multi_q = 1'b0;
                    timer_q = '0;
                    count_q = '0;
                end
                else if (cls == kda_pkg::CLS_PRESSED)
                begin
                    if (timer_q == '0)
                    begin
                        held_q = 1'b1;
                        if (count_q < kda_pkg::CNT_MAX)
                            count_q = count_q + kda_pkg::ONE;
                        timer_q = kcfg.long_reload;
                        if (count_q > kcfg.fast_after
                            && kcfg.enable_flags[kda_pkg::EN_FAST])
                            timer_q = kcfg.short_reload;
                        if (count_q > kcfg.multiply_after
                            && kcfg.enable_flags[kda_pkg::EN_MULTIPLY])
                            multi_q = 1'b1;
                    end
                    if (timer_q != '0 && kcfg.enable_flags[kda_pkg::EN_REPEAT])
                        timer_q = timer_q - kda_pkg::ONE;
                end
            end
        end
        rep.pressed_flag   = held_q;
        rep.multiply_flag  = multi_q;
        rep.filtered_state = class_q;
        rep.press_count    = count_q;
        return rep;
    endfunction

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : check_reports
        kda_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("%0t: unexpected report, expected none, actual %0d/%0d/%0d/%0d",
                         $time, pressed_flag, multiply_flag, filtered_state, press_count);
                errors++;
            end
            else
            begin
                want = expected_reports.pop_front();
                compare_field("pressed_flag", want.pressed_flag, pressed_flag);
                compare_field("multiply_flag", want.multiply_flag, multiply_flag);
                compare_field("filtered_state", want.filtered_state, filtered_state);
                compare_field("press_count", want.press_count, press_count);
            end
        end
    end

    task automatic send_item(input logic op_bit, input logic raw_bit);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid    <= 1'b1;
        op          <= op_bit;
        raw_pressed <= raw_bit;
        do
            @(posedge clk);
        while (in_stall);
        expected_reports.push_back(debounce_step(op_bit, raw_bit));
        items_sent++;
    endtask

    task automatic wait_drained();
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input kda_pkg::reg_idx_t idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            kda_pkg::REG_KEY_PRESENT:    kcfg.key_present    = val[0];
            kda_pkg::REG_ENABLE_FLAGS:   kcfg.enable_flags   = val[3:0];
            kda_pkg::REG_FILTER_MASK:    kcfg.filter_mask    = val;
            kda_pkg::REG_INVERT_LOGIC:   kcfg.invert_logic   = val[0];
            kda_pkg::REG_LONG_RELOAD:    kcfg.long_reload    = val;
            kda_pkg::REG_SHORT_RELOAD:   kcfg.short_reload   = val;
            kda_pkg::REG_FAST_AFTER:     kcfg.fast_after     = val;
            kda_pkg::REG_MULTIPLY_AFTER: kcfg.multiply_after = val;
            default: ;
        endcase
    endtask

    // Drop valid, let the block drain, then rewrite every register.
    task automatic apply_settings(input kda_pkg::cfg_t s);
        in_valid <= 1'b0;
        wait_drained();
        write_reg(kda_pkg::REG_KEY_PRESENT, {7'd0, s.key_present});
        write_reg(kda_pkg::REG_ENABLE_FLAGS, {4'd0, s.enable_flags});
        write_reg(kda_pkg::REG_FILTER_MASK, s.filter_mask);
        write_reg(kda_pkg::REG_INVERT_LOGIC, {7'd0, s.invert_logic});
        write_reg(kda_pkg::REG_LONG_RELOAD, s.long_reload);
        write_reg(kda_pkg::REG_SHORT_RELOAD, s.short_reload);
        write_reg(kda_pkg::REG_FAST_AFTER, s.fast_after);
        write_reg(kda_pkg::REG_MULTIPLY_AFTER, s.multiply_after);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte(input int unsigned typical_max);
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom_range(1, typical_max));
        endcase
    endfunction

    // Reset defaults: key absent and disabled, so everything reads released.
    task automatic test_reset_defaults();
        send_item(kda_pkg::OP_TICK, 1'b1);
        send_item(kda_pkg::OP_TICK, 1'b1);
        send_item(kda_pkg::OP_ACK, 1'b0);
        send_item(kda_pkg::OP_TICK, 1'b0);
    endtask

    task automatic test_press_repeat();
        apply_settings('{key_present: 1'b1, enable_flags: 4'hf, filter_mask: 8'h0f,
                         invert_logic: 1'b0, long_reload: 8'd2, short_reload: 8'd0,
                         fast_after: 8'd1, multiply_after: 8'd2});
        // three undecided ticks, then press, repeat, go fast and set multiply
        repeat (8) send_item(kda_pkg::OP_TICK, 1'b1);
        send_item(kda_pkg::OP_ACK, 1'b1);
        send_item(kda_pkg::OP_TICK, 1'b1);
        repeat (5) send_item(kda_pkg::OP_TICK, 1'b0);
    endtask

    task automatic test_special_cases();
        // empty mask reads pressed, inverted reads released
        apply_settings('{key_present: 1'b1, enable_flags: 4'hf, filter_mask: 8'h00,
                         invert_logic: 1'b0, long_reload: 8'd2, short_reload: 8'd1,
                         fast_after: 8'd0, multiply_after: 8'd0});
        send_item(kda_pkg::OP_TICK, 1'b0);
        apply_settings('{key_present: 1'b1, enable_flags: 4'hf, filter_mask: 8'h00,
                         invert_logic: 1'b1, long_reload: 8'd2, short_reload: 8'd1,
                         fast_after: 8'd0, multiply_after: 8'd0});
        send_item(kda_pkg::OP_TICK, 1'b0);
        // repeat disabled: the timer holds its reload, no second event
        apply_settings('{key_present: 1'b1, enable_flags: 4'h1, filter_mask: 8'h0f,
                         invert_logic: 1'b0, long_reload: 8'd2, short_reload: 8'd1,
                         fast_after: 8'd0, multiply_after: 8'd0});
        repeat (6) send_item(kda_pkg::OP_TICK, 1'b1);
        // key disabled forces released
        apply_settings('{key_present: 1'b1, enable_flags: 4'h0, filter_mask: 8'h0f,
                         invert_logic: 1'b0, long_reload: 8'd2, short_reload: 8'd1,
                         fast_after: 8'd0, multiply_after: 8'd0});
        send_item(kda_pkg::OP_TICK, 1'b1);
        // key absent: only the history and the class move
        apply_settings('{key_present: 1'b0, enable_flags: 4'hf, filter_mask: 8'h03,
                         invert_logic: 1'b0, long_reload: 8'd0, short_reload: 8'd0,
                         fast_after: 8'd0, multiply_after: 8'd0});
        send_item(kda_pkg::OP_TICK, 1'b1);
        send_item(kda_pkg::OP_TICK, 1'b1);
        send_item(kda_pkg::OP_ACK, 1'b0);
    endtask

    task automatic test_random_strokes(input int unsigned n_items);
        kda_pkg::cfg_t s;
        int unsigned   stop_at;
        int unsigned   hold;
        s.key_present  = ($urandom_range(0, 9) != 0);
        s.enable_flags = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 7) != 0)
            s.enable_flags[kda_pkg::EN_KEY] = 1'b1;
        case ($urandom_range(0, 5))
            0:       s.filter_mask = 8'hff;
            1:       s.filter_mask = 8'h0f;
            2:       s.filter_mask = 8'h03;
            3:       s.filter_mask = 8'h01;
            4:       s.filter_mask = 8'h00;
            default: s.filter_mask = 8'($urandom_range(0, 255));
        endcase
        s.invert_logic   = ($urandom_range(0, 3) == 0);
        s.long_reload    = pick_byte(6);
        s.short_reload   = pick_byte(4);
        s.fast_after     = pick_byte(8);
        s.multiply_after = pick_byte(10);
        apply_settings(s);
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                repeat ($urandom_range(1, 10))
                    send_item(($urandom_range(0, 4) == 0) ? kda_pkg::OP_ACK
                                                          : kda_pkg::OP_TICK,
                              1'($urandom_range(0, 1)));
            end
            else
            begin
                hold = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 120)
                                                    : $urandom_range(1, 30);
                // bounce in, hold with the odd acknowledge, bounce out, rest
                repeat ($urandom_range(0, 3))
                    send_item(kda_pkg::OP_TICK, 1'($urandom_range(0, 1)));
                repeat (hold)
                    send_item(($urandom_range(0, 24) == 0) ? kda_pkg::OP_ACK
                                                           : kda_pkg::OP_TICK, 1'b1);
                repeat ($urandom_range(0, 3))
                    send_item(kda_pkg::OP_TICK, 1'($urandom_range(0, 1)));
                repeat ($urandom_range(1, 12))
                    send_item(($urandom_range(0, 24) == 0) ? kda_pkg::OP_ACK
                                                           : kda_pkg::OP_TICK, 1'b0);
            end
        end
    endtask

    // Zero reloads make every pressed tick an event, so the count hits its ceiling.
    task automatic test_count_saturation();
        apply_settings('{key_present: 1'b1, enable_flags: 4'hf, filter_mask: 8'h01,
                         invert_logic: 1'b0, long_reload: 8'd0, short_reload: 8'd0,
                         fast_after: 8'd0, multiply_after: 8'd0});
        repeat (4) send_item(kda_pkg::OP_TICK, 1'b0);
        repeat (275)
            send_item(($urandom_range(0, 29) == 0) ? kda_pkg::OP_ACK
                                                   : kda_pkg::OP_TICK, 1'b1);
        repeat (6) send_item(kda_pkg::OP_TICK, 1'b0);
    endtask

    initial
    begin
        send_idle_pct = 34;
        recv_idle_pct = 79;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_press_repeat();
        test_special_cases();

        repeat (3) test_random_strokes(150);
        send_idle_pct = 79;
        recv_idle_pct = 34;
        repeat (3) test_random_strokes(150);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) test_random_strokes(150);
        test_count_saturation();

        in_valid <= 1'b0;
        wait_drained();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
src/kda_pkg.sv
src/kda_cfg_regs.sv
src/kda_core.sv
src/kda_out_buf.sv
src/key_debounce_autorepeat_core.sv
dv/tb_key_debounce_autorepeat_core.sv
